// ----- rtl/qst_pkg.sv -----
// Shared types and constants of the quoted shell tokenizer.
// Used by every module under rtl; depends on nothing.
package qst_pkg;

	localparam int unsigned CapWidth   = 16;
	localparam int unsigned LenWidth   = 16;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

	localparam logic [CapWidth-1:0] CapReset = 16'd64;

	localparam logic [ByteWidth-1:0] ChBackslash = 8'h5C;
	localparam logic [ByteWidth-1:0] ChSquote    = 8'h27;
	localparam logic [ByteWidth-1:0] ChDquote    = 8'h22;
	localparam logic [ByteWidth-1:0] ChSpace     = 8'h20;
	localparam logic [ByteWidth-1:0] ChTab       = 8'h09;
	localparam logic [ByteWidth-1:0] ChLf        = 8'h0A;
	localparam logic [ByteWidth-1:0] ChCr        = 8'h0D;

	localparam int unsigned RegTokenCapacity = 0;

	typedef enum logic [2:0] {
		K_BYTE = 3'd0,
		K_DONE = 3'd1,
		K_BADQ = 3'd2,
		K_LONG = 3'd3,
		K_EOL  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WORD    = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_t;

	typedef struct packed {
		kind_t                 kind;
		logic [ByteWidth-1:0]  word_byte;
		logic [LenWidth-1:0]   word_length;
		logic                  last;
	} result_t;

	// Up to two results per request, both written to the queue in the same cycle.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_sep(input logic [ByteWidth-1:0] c);
		return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
	endfunction

endpackage

// ----- rtl/qst_cfg.sv -----
// APB-style register file holding token_capacity.
// Depends on qst_pkg.
module qst_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [qst_pkg::CapWidth-1:0]  cap
);
	import qst_pkg::*;

	logic [CapWidth-1:0] cap_q;
	logic                sel_cap;

	assign sel_cap = (paddr[2] == RegTokenCapacity[0]);
	assign pready  = 1'b1;
	assign cap     = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			cap_q <= pwdata[CapWidth-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata = {{(32-CapWidth){1'b0}}, cap_q};
		end
	end

endmodule

// ----- rtl/qst_core.sv -----
// Input register, word-splitting state and the per-byte decision logic.
// Depends on qst_pkg; feeds qst_resq.
module qst_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [qst_pkg::ByteWidth-1:0] text_byte,
	input  logic                          end_of_line,
	input  logic [qst_pkg::CapWidth-1:0]  cap,
	input  logic                          room,
	output qst_pkg::push_t                push
);
	import qst_pkg::*;

	logic                  valid_s1;
	logic [ByteWidth-1:0]  byte_s1;
	logic                  eol_s1;
	logic                  adv;

	phase_t                phase_q, phase_n;
	quote_t                quote_q, quote_n;
	logic                  esc_q, esc_n;
	logic [LenWidth-1:0]   len_q, len_n;

	logic                  sep;
	logic                  literal;
	logic [LenWidth:0]     len_inc;
	push_t                 step;

	assign adv      = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign sep      = is_sep(byte_s1);
	assign len_inc  = {1'b0, len_q} + {{LenWidth{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= text_byte;
			eol_s1  <= end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			quote_q <= Q_NONE;
			esc_q   <= 1'b0;
			len_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			quote_q <= quote_n;
			esc_q   <= esc_n;
			len_q   <= len_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		quote_n = quote_q;
		esc_n   = esc_q;
		len_n   = len_q;
		literal = 1'b0;
		step.n  = 2'd0;
		step.r0 = '{kind: K_BYTE, word_byte: '0, word_length: '0, last: 1'b0};
		step.r1 = '{kind: K_EOL, word_byte: '0, word_length: '0, last: 1'b1};
		if (eol_s1) begin
			if (phase_q == PH_WORD) begin
				step.n           = 2'd2;
				step.r0.kind     = (esc_q || quote_q != Q_NONE) ? K_BADQ : K_DONE;
				step.r0.word_length = len_q;
			end else begin
				step.n  = 2'd1;
				step.r0 = step.r1;
			end
			phase_n = PH_IDLE;
			quote_n = Q_NONE;
			esc_n   = 1'b0;
			len_n   = '0;
		end else if (phase_q != PH_DISCARD && !(phase_q == PH_IDLE && sep)) begin
			phase_n = PH_WORD;
			priority if (esc_q) begin
				esc_n   = 1'b0;
				literal = 1'b1;
			end else if (quote_q == Q_NONE && sep) begin
				step.n              = 2'd1;
				step.r0.kind        = K_DONE;
				step.r0.word_length = len_q;
				step.r0.last        = 1'b1;
				phase_n = PH_IDLE;
				len_n   = '0;
			end else if (byte_s1 == ChBackslash && quote_q != Q_SINGLE) begin
				esc_n = 1'b1;
			end else if (byte_s1 == ChSquote && quote_q != Q_DOUBLE) begin
				quote_n = (quote_q == Q_NONE) ? Q_SINGLE : Q_NONE;
			end else if (byte_s1 == ChDquote && quote_q != Q_SINGLE) begin
				quote_n = (quote_q == Q_NONE) ? Q_DOUBLE : Q_NONE;
			end else begin
				literal = 1'b1;
			end
			if (literal) begin
				step.n       = 2'd1;
				step.r0.last = 1'b1;
				if (len_inc >= {1'b0, cap}) begin
					step.r0.kind        = K_LONG;
					step.r0.word_length = len_q;
					phase_n = PH_DISCARD;
					quote_n = Q_NONE;
					esc_n   = 1'b0;
					len_n   = '0;
				end else begin
					step.r0.word_byte   = byte_s1;
					step.r0.word_length = len_inc[LenWidth-1:0];
					len_n = len_inc[LenWidth-1:0];
				end
			end
		end
	end

	always_comb begin
		push   = step;
		push.n = adv ? step.n : 2'd0;
	end

	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISCARD |-> (quote_q == Q_NONE && !esc_q && len_q == '0))
		else $error("discard phase holds word state");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (quote_q == Q_NONE && !esc_q && len_q == '0))
		else $error("idle phase holds word state");

	a_eol_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eol_s1 |=> phase_q == PH_IDLE)
		else $error("line end did not return to idle");

endmodule

// ----- rtl/qst_resq.sv -----
// Small result queue: takes up to two results a cycle while it has room, hands out one unless out_stall holds.
// Depends on qst_pkg; decouples the core from output stalls.
module qst_resq (
	input  logic                clk,
	input  logic                arst_n,
	input  qst_pkg::push_t      push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output qst_pkg::result_t    head
);
	import qst_pkg::*;

	result_t              mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_q;
	logic [QueuePtrW-1:0] rd_q;
	logic [QueuePtrW:0]   cnt_q;
	logic                 pop;
	logic [QueuePtrW-1:0] wr_nxt;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q <= (QueuePtrW + 1)'(QueueDepth - 2));
	assign head      = mem_q[rd_q];
	assign wr_nxt    = wr_q + {{(QueuePtrW-1){1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_nxt] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QueuePtrW'(push.n);
			rd_q  <= rd_q + QueuePtrW'(pop);
			cnt_q <= cnt_q + (QueuePtrW + 1)'(push.n) - (QueuePtrW + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QueuePtrW + 1)'(QueueDepth))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not drain queue");

endmodule

// ----- rtl/quoted_shell_tokenizer.sv -----
// channel  | handshake            | payload
// request  | in_valid / in_stall  | text_byte, end_of_line
// result   | out_valid / out_stall| kind, word_byte, word_length, last
// config   | APB psel/penable     | token_capacity at byte address 0
// One request per cycle while in_stall is low: input register, combinational
// decision logic, then a four-entry result queue. A line end inside a word
// gives two results. Requests stall only when the queue lacks room for two
// results. Reset clears the word state and sets token_capacity to 64.
module quoted_shell_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  word_byte,
	output logic [15:0] word_length,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qst_pkg::*;

	logic [CapWidth-1:0] cap;
	logic                room;
	push_t               push;
	result_t             head;

	qst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap)
	);

	qst_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_line (end_of_line),
		.cap         (cap),
		.room        (room),
		.push        (push)
	);

	qst_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind        = head.kind;
	assign word_byte   = head.word_byte;
	assign word_length = head.word_length;
	assign last        = head.last;

endmodule
